// File: design/vrsp_pkg.sv
// ----------------------------------------------------------------------------
// vrsp_pkg
// Shared types and constants for the variable-rate sample player.
// ----------------------------------------------------------------------------
package vrsp_pkg;

  localparam int SAMPLE_DEPTH = 65536;
  localparam int MAX_CHANNELS = 8;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int CH_W         = 3;
  localparam int POS_W        = 19;
  localparam int RA_W         = POS_W + 1;
  localparam int PADDR_W      = 5;

  localparam logic [19:0] RATE_RESET = 20'sd65536;
  localparam logic [16:0] ONE        = 17'd65536;
  localparam logic signed [19:0] RATE_MIN = 20'sh80000;
  localparam logic signed [19:0] RATE_MAX = 20'sh7FFFF;

  // register indexes
  localparam logic [2:0] REG_CHANNELS      = 3'd0;
  localparam logic [2:0] REG_LOOP_MODE     = 3'd1;
  localparam logic [2:0] REG_INTERP_MODE   = 3'd2;
  localparam logic [2:0] REG_PLAYBACK_RATE = 3'd3;
  localparam logic [2:0] REG_LOOP_START    = 3'd4;
  localparam logic [2:0] REG_LOOP_END      = 3'd5;

  // input func codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // loop modes
  localparam logic [1:0] MODE_STOP     = 2'd0;
  localparam logic [1:0] MODE_REPEAT   = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_TICK
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ENDED,
    S_READ,
    S_FETCH,
    S_REFILL,
    S_PUSH,
    S_MUL,
    S_EMIT,
    S_ADV
  } state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        addr;
    logic signed [15:0] data;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [2:0]         channel;
    logic               last;
    logic               ended;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        addr;
    logic signed [15:0] data;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         channels;
    logic [1:0]         loop_mode;
    logic               interp_mode;
    logic signed [19:0] playback_rate;
    logic [15:0]        loop_start;
    logic [16:0]        loop_end;
  } cfg_t;

endpackage

// File: design/vrsp_front.sv
// ----------------------------------------------------------------------------
// vrsp_front
// Accepts input beats, decodes func and queues commands for the back end.
// ----------------------------------------------------------------------------
module vrsp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  vrsp_pkg::in_item_t item,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output vrsp_pkg::cmd_t     cmd
);

  vrsp_pkg::cmd_t queue [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  vrsp_pkg::op_t  op;
  logic           push;
  logic           pop;

  always_comb begin
    unique case (item.func)
      vrsp_pkg::FUNC_LOAD:  op = vrsp_pkg::OP_LOAD;
      vrsp_pkg::FUNC_START: op = vrsp_pkg::OP_START;
      vrsp_pkg::FUNC_TICK:  op = vrsp_pkg::OP_TICK;
      default:              op = vrsp_pkg::OP_NONE;
    endcase
  end

  assign item_ready = (count != 2'd2);
  // unknown codes are dropped here and never reach the back end
  assign push       = item_valid && item_ready && (op != vrsp_pkg::OP_NONE);
  assign cmd_valid  = (count != 2'd0);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = queue[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= '{op: op, addr: item.addr, data: item.data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !pop) else $error("pop from empty queue");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue count did not advance on push");

endmodule

// File: design/vrsp_back.sv
// ----------------------------------------------------------------------------
// vrsp_back
// Executes load, start and tick commands: sample memory, playback state,
// interpolation points and the output register.
// ----------------------------------------------------------------------------
module vrsp_back (
  input  logic                clk,
  input  logic                rst,
  input  vrsp_pkg::cfg_t      cfg,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  vrsp_pkg::cmd_t      cmd,
  output logic                result_valid,
  input  logic                result_ready,
  output vrsp_pkg::out_item_t result
);

  localparam int POS_W = vrsp_pkg::POS_W;
  localparam int RA_W  = vrsp_pkg::RA_W;
  localparam int AW    = vrsp_pkg::ADDR_W;
  localparam int CH_W  = vrsp_pkg::CH_W;

  vrsp_pkg::state_t state, state_next;

  logic signed [15:0] mem [vrsp_pkg::SAMPLE_DEPTH];
  logic signed [15:0] mem_q;
  logic               oob_q;

  logic signed [POS_W-1:0] position;
  logic signed [16:0]      fraction;
  logic signed [19:0]      rate;
  logic                    playing;
  logic [1:0]              point_count;
  logic signed [15:0]      older [vrsp_pkg::MAX_CHANNELS];
  logic signed [15:0]      newer [vrsp_pkg::MAX_CHANNELS];
  logic [CH_W-1:0]         chan;
  logic                    wrapped;
  logic signed [15:0]      res_q;
  logic signed [15:0]      old_q;
  logic signed [15:0]      val_q;
  logic signed [33:0]      prod;

  logic [3:0]              n;
  logic signed [POS_W-1:0] n_s;
  logic signed [POS_W-1:0] c_s;
  logic signed [POS_W-1:0] lstart_s;
  logic signed [POS_W-1:0] lend_s;
  logic signed [POS_W-1:0] lend_back;
  logic                    outside;
  logic signed [16:0]      fabs;
  logic [15:0]             mag;
  logic signed [20:0]      fr_minus_rate;
  logic                    cross_fwd;
  logic                    cross_bwd;
  logic                    refill;
  logic                    push_pt;
  logic                    last_ch;
  logic                    out_free;
  logic signed [RA_W-1:0]  rd_addr;
  logic                    rd_en;
  logic                    rd_oob;
  logic signed [15:0]      rd_val;
  logic signed [15:0]      new_pt;
  logic signed [15:0]      old_pt;
  logic [1:0]              count_after;
  logic signed [16:0]      diff;
  logic signed [33:0]      blend;
  logic signed [33:0]      blend_t;
  logic signed [20:0]      sum;
  logic signed [20:0]      neg_sum;
  logic signed [5:0]       whole;
  logic signed [16:0]      frac_next;
  logic signed [10:0]      step;

  // clamp channel count to 1..MAX_CHANNELS
  always_comb begin
    if (cfg.channels == 4'd0) begin
      n = 4'd1;
    end else if (cfg.channels > 4'(vrsp_pkg::MAX_CHANNELS)) begin
      n = 4'(vrsp_pkg::MAX_CHANNELS);
    end else begin
      n = cfg.channels;
    end
  end

  assign n_s       = $signed(POS_W'(n));
  assign c_s       = $signed(POS_W'(chan));
  assign lstart_s  = $signed(POS_W'(cfg.loop_start));
  assign lend_s    = $signed(POS_W'(cfg.loop_end));
  assign lend_back = lend_s - n_s;
  assign outside   = rate[19] ? (position < lstart_s) : (position >= lend_s);
  assign last_ch   = ({1'b0, chan} == (n - 4'd1));
  assign out_free  = !result_valid || result_ready;

  assign fabs          = fraction[16] ? -fraction : fraction;
  assign mag           = fabs[15:0];
  assign fr_minus_rate = 21'(fraction) - 21'(rate);
  assign cross_fwd     = !rate[19] && (rate != 20'sd0) && fr_minus_rate[20];
  assign cross_bwd     = rate[19] && !fr_minus_rate[20] && (fr_minus_rate != 21'sd0);
  assign refill        = (cross_fwd && (rate > 20'sd65536))
                      || (cross_bwd && (rate < -20'sd65536));
  assign push_pt       = (mag == 16'd0) || cross_fwd || cross_bwd;
  assign rd_val        = oob_q ? 16'sd0 : mem_q;

  // post-push points for the blend
  assign new_pt      = push_pt ? res_q : newer[chan];
  assign old_pt      = push_pt ? newer[chan] : older[chan];
  assign count_after = (push_pt && point_count != 2'd2) ? point_count + 2'd1 : point_count;
  assign diff        = 17'(new_pt) - 17'(old_pt);
  assign blend       = (34'(old_q) <<< 16) + prod;
  assign blend_t     = blend[33] ? blend + 34'sd65535 : blend;

  // advance: add rate to fraction, whole part truncated toward zero
  assign sum     = 21'(fraction) + 21'(rate);
  assign neg_sum = -sum;
  always_comb begin
    if (sum[20]) begin
      whole     = -$signed({1'b0, neg_sum[20:16]});
      frac_next = -$signed({1'b0, neg_sum[15:0]});
    end else begin
      whole     = $signed({1'b0, sum[20:16]});
      frac_next = $signed({1'b0, sum[15:0]});
    end
  end
  assign step = 11'(whole) * $signed({7'd0, n});

  // memory read address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = RA_W'(position) + RA_W'(c_s);
    if (state == vrsp_pkg::S_READ) begin
      rd_en = 1'b1;
    end else if (state == vrsp_pkg::S_FETCH) begin
      rd_en = 1'b1;
      if (cross_fwd) begin
        rd_addr = RA_W'(position) - RA_W'(n_s) + RA_W'(c_s);
      end else begin
        rd_addr = RA_W'(position) + RA_W'(n_s) + RA_W'(c_s);
      end
    end
  end
  assign rd_oob = rd_addr[RA_W-1] || (rd_addr >= RA_W'(vrsp_pkg::SAMPLE_DEPTH));

  always_ff @(posedge clk) begin
    if (state == vrsp_pkg::S_IDLE && cmd_valid && cmd.op == vrsp_pkg::OP_LOAD) begin
      mem[cmd.addr[AW-1:0]] <= cmd.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr[AW-1:0]];
      oob_q <= rd_oob;
    end
  end

  assign cmd_ready = (state == vrsp_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= vrsp_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      vrsp_pkg::S_IDLE: begin
        if (cmd_valid && cmd.op == vrsp_pkg::OP_TICK && playing) begin
          state_next = vrsp_pkg::S_CHECK;
        end
      end
      vrsp_pkg::S_CHECK: begin
        if (!outside) begin
          state_next = vrsp_pkg::S_READ;
        end else if (wrapped || !(cfg.loop_mode == vrsp_pkg::MODE_REPEAT
                                  || cfg.loop_mode == vrsp_pkg::MODE_PINGPONG)) begin
          state_next = vrsp_pkg::S_ENDED;
        end
      end
      vrsp_pkg::S_ENDED: begin
        if (out_free) state_next = vrsp_pkg::S_IDLE;
      end
      vrsp_pkg::S_READ: state_next = vrsp_pkg::S_FETCH;
      vrsp_pkg::S_FETCH: begin
        if (cfg.interp_mode && mag != 16'd0 && refill) state_next = vrsp_pkg::S_REFILL;
        else                                            state_next = vrsp_pkg::S_PUSH;
      end
      vrsp_pkg::S_REFILL: state_next = vrsp_pkg::S_PUSH;
      vrsp_pkg::S_PUSH: begin
        if (cfg.interp_mode && mag != 16'd0 && count_after > 2'd1) begin
          state_next = vrsp_pkg::S_MUL;
        end else begin
          state_next = vrsp_pkg::S_EMIT;
        end
      end
      vrsp_pkg::S_MUL: state_next = vrsp_pkg::S_EMIT;
      vrsp_pkg::S_EMIT: begin
        if (out_free) state_next = last_ch ? vrsp_pkg::S_ADV : vrsp_pkg::S_READ;
      end
      vrsp_pkg::S_ADV: state_next = vrsp_pkg::S_IDLE;
      default: state_next = vrsp_pkg::S_IDLE;
    endcase
  end

  // playback control state
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      fraction    <= '0;
      rate        <= '0;
      playing     <= 1'b0;
      point_count <= 2'd0;
      wrapped     <= 1'b0;
      chan        <= '0;
      for (int i = 0; i < vrsp_pkg::MAX_CHANNELS; i++) begin
        older[i] <= '0;
        newer[i] <= '0;
      end
    end else begin
      unique case (state)
        vrsp_pkg::S_IDLE: begin
          wrapped <= 1'b0;
          chan    <= '0;
          if (cmd_valid && cmd.op == vrsp_pkg::OP_START) begin
            fraction <= '0;
            rate     <= cfg.playback_rate;
            playing  <= 1'b1;
            position <= (cfg.playback_rate > 20'sd0) ? lstart_s : lend_back;
            for (int i = 0; i < vrsp_pkg::MAX_CHANNELS; i++) begin
              older[i] <= '0;
              newer[i] <= '0;
            end
          end
        end
        vrsp_pkg::S_CHECK: begin
          if (outside && !wrapped) begin
            wrapped <= 1'b1;
            if (cfg.loop_mode == vrsp_pkg::MODE_REPEAT) begin
              position <= rate[19] ? lend_back : lstart_s;
            end else if (cfg.loop_mode == vrsp_pkg::MODE_PINGPONG) begin
              position <= rate[19] ? lstart_s : lend_back;
              rate     <= (rate == vrsp_pkg::RATE_MIN) ? vrsp_pkg::RATE_MAX : -rate;
            end
          end
        end
        vrsp_pkg::S_ENDED: begin
          if (out_free) playing <= 1'b0;
        end
        vrsp_pkg::S_REFILL: begin
          newer[chan] <= rd_val;
        end
        vrsp_pkg::S_PUSH: begin
          if (cfg.interp_mode && push_pt) begin
            older[chan] <= newer[chan];
            newer[chan] <= res_q;
            point_count <= count_after;
          end
        end
        vrsp_pkg::S_EMIT: begin
          if (out_free && !last_ch) chan <= chan + CH_W'(1);
        end
        vrsp_pkg::S_ADV: begin
          fraction <= frac_next;
          position <= position + POS_W'(step);
        end
        default: begin
        end
      endcase
    end
  end

  // per-channel datapath
  always_ff @(posedge clk) begin
    if (state == vrsp_pkg::S_FETCH) res_q <= rd_val;
    if (state == vrsp_pkg::S_PUSH) begin
      old_q <= old_pt;
      prod  <= $signed({1'b0, mag}) * diff;
      if (!cfg.interp_mode)   val_q <= res_q;
      else if (mag == 16'd0)  val_q <= newer[chan];
      else                    val_q <= res_q;
    end
    if (state == vrsp_pkg::S_MUL) val_q <= blend_t[31:16];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free && (state == vrsp_pkg::S_EMIT || state == vrsp_pkg::S_ENDED)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state == vrsp_pkg::S_EMIT) begin
      result <= '{sample: val_q, channel: chan, last: last_ch, ended: 1'b0};
    end else if (out_free && state == vrsp_pkg::S_ENDED) begin
      result <= '{sample: 16'sd0, channel: '0, last: 1'b1, ended: 1'b1};
    end
  end

  a_ended_stops: assert property (@(posedge clk) disable iff (rst)
    (state == vrsp_pkg::S_ENDED && out_free) |=> (!playing && result_valid && result.ended))
    else $error("ended beat without stopping playback");

  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, chan} < n)) else $error("channel index beyond channel count");

  a_points: assert property (@(posedge clk) disable iff (rst)
    point_count <= 2'd2) else $error("point count overflow");

  a_emit_sample: assert property (@(posedge clk) disable iff (rst)
    (state == vrsp_pkg::S_EMIT && out_free) |=> (result_valid && !result.ended))
    else $error("sample beat not presented");

endmodule

// File: design/variable_rate_sample_player_top.sv
// ----------------------------------------------------------------------------
// variable_rate_sample_player_top
// Variable-rate interleaved sample player with nearest or linear interpolation.
// ----------------------------------------------------------------------------
// Sequence: a tick taken in idle goes through check, read, fetch, push and emit before
//   its first sample beat is registered; a refill read, a blend multiply and a loop
//   wrap add a state each, and an end beat goes through check and ended. Commands are
//   taken only in idle; a tick walks read, fetch, push and emit for each of n channels,
//   with a registered sample memory read and a blend multiplier shared by all channels.
// Reset: synchronous rst clears control state and registers; sample memory undefined.
module variable_rate_sample_player_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  vrsp_pkg::in_item_t                   item,
  // result items
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output vrsp_pkg::out_item_t                  result,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vrsp_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  vrsp_pkg::cfg_t cfg;
  vrsp_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;
  logic           cfg_we;
  logic [2:0]     reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  // write on the access phase of a write beat
  assign cfg_we    = psel && penable && pwrite && pready;

  // register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channels      <= 4'd1;
      cfg.loop_mode     <= vrsp_pkg::MODE_STOP;
      cfg.interp_mode   <= 1'b0;
      cfg.playback_rate <= vrsp_pkg::RATE_RESET;
      cfg.loop_start    <= 16'd0;
      cfg.loop_end      <= 17'd65536;
    end else if (cfg_we) begin
      unique case (reg_index)
        vrsp_pkg::REG_CHANNELS:      cfg.channels      <= pwdata[3:0];
        vrsp_pkg::REG_LOOP_MODE:     cfg.loop_mode     <= pwdata[1:0];
        vrsp_pkg::REG_INTERP_MODE:   cfg.interp_mode   <= pwdata[0];
        vrsp_pkg::REG_PLAYBACK_RATE: cfg.playback_rate <= pwdata[19:0];
        vrsp_pkg::REG_LOOP_START:    cfg.loop_start    <= pwdata[15:0];
        vrsp_pkg::REG_LOOP_END:      cfg.loop_end      <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  // readback, rate sign-extended
  always_comb begin
    unique case (reg_index)
      vrsp_pkg::REG_CHANNELS:      prdata = 32'(cfg.channels);
      vrsp_pkg::REG_LOOP_MODE:     prdata = 32'(cfg.loop_mode);
      vrsp_pkg::REG_INTERP_MODE:   prdata = 32'(cfg.interp_mode);
      vrsp_pkg::REG_PLAYBACK_RATE: prdata = 32'(cfg.playback_rate);
      vrsp_pkg::REG_LOOP_START:    prdata = 32'(cfg.loop_start);
      vrsp_pkg::REG_LOOP_END:      prdata = 32'(cfg.loop_end);
      default:                     prdata = 32'd0;
    endcase
  end

  // front: accept and decode beats, hold them in a short queue
  vrsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // back: memory, playback sequencer and output register
  vrsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: tb/sv/variable_rate_sample_player_top_tb.sv
// ----------------------------------------------------------------------------
// variable_rate_sample_player_top_tb
// Self-checking bench: loads sample words, plays them back under many register
// settings and checks every sample beat against an in-bench player model.
// ----------------------------------------------------------------------------
module variable_rate_sample_player_top_tb;

  // func code with no meaning in the block; it must be swallowed silently
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int RATE_LO = -524288;
  localparam int RATE_HI = 524287;
  localparam int UNITY   = 65536;
  localparam int SETTLE_CYCLES = 64;

  // --------------------------------------------------------------------------
  // Player model and store of expected sample beats
  // --------------------------------------------------------------------------
  class sample_scoreboard;
    logic signed [15:0] words [int];
    int pos, frac, rate, pts_n;
    bit running;
    logic signed [15:0] pts [2*vrsp_pkg::MAX_CHANNELS];
    int nch_reg, lmode, imode, prate, lstart, lend;
    vrsp_pkg::out_item_t pending_q [$];
    int errors, beats, end_beats, items;

    function new();
      nch_reg = 1; lmode = 0; imode = 0; prate = UNITY; lstart = 0; lend = 65536;
      pos = 0; frac = 0; rate = 0; running = 0; pts_n = 0;
      foreach (pts[i]) pts[i] = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        vrsp_pkg::REG_CHANNELS:      nch_reg = int'(v[3:0]);
        vrsp_pkg::REG_LOOP_MODE:     lmode = int'(v[1:0]);
        vrsp_pkg::REG_INTERP_MODE:   imode = int'(v[0]);
        vrsp_pkg::REG_PLAYBACK_RATE: prate = int'($signed(v[19:0]));
        vrsp_pkg::REG_LOOP_START:    lstart = int'(v[15:0]);
        vrsp_pkg::REG_LOOP_END:      lend = int'(v[16:0]);
        default: ;
      endcase
    endfunction

    function int chans();
      if (nch_reg < 1) return 1;
      if (nch_reg > vrsp_pkg::MAX_CHANNELS) return vrsp_pkg::MAX_CHANNELS;
      return nch_reg;
    endfunction

    function int peek(longint a);
      if (a < 0 || a >= vrsp_pkg::SAMPLE_DEPTH) return 0;
      if (!words.exists(int'(a))) return 0;
      return words[int'(a)];
    endfunction

    function bit beyond();
      if (rate >= 0) return pos >= lend;
      return pos < lstart;
    endfunction

    function void push_pt(int c, int v);
      pts[2*c] = pts[2*c+1];
      pts[2*c+1] = 16'(v);
      if (pts_n < 2) pts_n++;
    endfunction

    function int blend_channel(int c, int n);
      int res, mag;
      longint acc;
      res = peek(longint'(pos) + c);
      if (imode == 0) return res;
      mag = frac < 0 ? -frac : frac;
      if (mag == 0) begin
        push_pt(c, res);
        return pts[2*c];
      end
      if (rate > 0 && frac - rate < 0) begin
        // refill the newer point from the neighbouring frame on fast playback
        if (rate > UNITY) pts[2*c+1] = 16'(peek(longint'(pos) - n + c));
        push_pt(c, res);
      end else if (rate < 0 && frac - rate > 0) begin
        if (rate < -UNITY) pts[2*c+1] = 16'(peek(longint'(pos) + n + c));
        push_pt(c, res);
      end
      if (pts_n > 1) begin
        acc = longint'(mag) * pts[2*c+1] + longint'(UNITY - mag) * pts[2*c];
        res = int'(acc / UNITY);
      end
      return res;
    endfunction

    function void add_beat(int s, int ch, bit lst, bit ended);
      vrsp_pkg::out_item_t o;
      o.sample = s[15:0];
      o.channel = ch[2:0];
      o.last = lst;
      o.ended = ended;
      pending_q.push_back(o);
    endfunction

    function void note_item(vrsp_pkg::in_item_t it);
      int n, sum, whole;
      bit fwd;
      items++;
      n = chans();
      case (it.func)
        vrsp_pkg::FUNC_LOAD: words[int'(it.addr)] = it.data;
        vrsp_pkg::FUNC_START: begin
          foreach (pts[i]) pts[i] = '0;
          frac = 0;
          rate = prate;
          pos = rate > 0 ? lstart : lend - n;
          running = 1;
        end
        vrsp_pkg::FUNC_TICK: begin
          if (!running) return;
          if (beyond()) begin
            fwd = rate >= 0;
            if (lmode == vrsp_pkg::MODE_REPEAT) begin
              pos = fwd ? lstart : lend - n;
            end else if (lmode == vrsp_pkg::MODE_PINGPONG) begin
              pos = fwd ? lend - n : lstart;
              rate = rate == RATE_LO ? RATE_HI : -rate;
            end
            if (lmode == vrsp_pkg::MODE_STOP || lmode == 3 || beyond()) begin
              running = 0;
              add_beat(0, 0, 1, 1);
              return;
            end
          end
          for (int c = 0; c < n; c++) add_beat(blend_channel(c, n), c, c == n - 1, 0);
          sum = frac + rate;
          whole = sum >= 0 ? sum / UNITY : -((-sum) / UNITY);
          frac = sum - whole * UNITY;
          pos += whole * n;
        end
        default: ;
      endcase
    endfunction

    function void check_result(vrsp_pkg::out_item_t r);
      vrsp_pkg::out_item_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: sample %0d channel %0d", r.sample, r.channel);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      beats++;
      if (r.ended) end_beats++;
      if (r.sample !== e.sample) begin
        $error("sample: expected %0d, got %0d", e.sample, r.sample); errors++;
      end
      if (r.channel !== e.channel) begin
        $error("channel: expected %0d, got %0d", e.channel, r.channel); errors++;
      end
      if (r.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, r.last); errors++;
      end
      if (r.ended !== e.ended) begin
        $error("ended: expected %0d, got %0d", e.ended, r.ended); errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and the block
  // --------------------------------------------------------------------------
  logic clk, rst;
  logic item_valid, item_ready, result_valid, result_ready;
  vrsp_pkg::in_item_t item;
  vrsp_pkg::out_item_t result;
  logic psel, penable, pwrite, pready;
  logic [vrsp_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  sample_scoreboard sb;
  bit eager_tx, eager_rx, hold_req, hold_rx;

  variable_rate_sample_player_top u_dut (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 0;
    sb = new();
  end
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Monitor both channels on the edge itself; all block outputs still hold
  // their pre-edge values here, so the sampling is free of ordering races.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) sb.note_item(item);
      if (result_valid && result_ready) sb.check_result(result);
    end
  end

  // Mostly short gaps, now and then a long one; none in eager stretches.
  function automatic int gap_len(bit eager);
    int r;
    if (eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, plus the long hold-off when asked.
  initial begin
    int stall_left;
    stall_left = 0;
    result_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall_left > 0) stall_left--;
      else stall_left = gap_len(eager_rx);
      result_ready <= !hold_rx && stall_left == 0;
    end
  end

  // Long hold-off on the result side, counted here while the sender keeps on.
  initial begin
    hold_rx = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_rx <= 1;
        repeat (400) @(posedge clk);
        hold_rx <= 0;
        hold_req = 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  // Offer one beat and hold it until accepted.
  task automatic send_item(logic [1:0] func, logic [15:0] addr, logic [15:0] data);
    int g;
    g = gap_len(eager_tx);
    if (g > 0) begin
      item_valid <= 0;
      repeat (g) @(posedge clk);
    end
    item_valid <= 1;
    item <= '{func: func, addr: addr, data: data};
    do @(posedge clk); while (!item_ready);
  endtask

  // Drop valid and wait out every expected beat, then the block's tail.
  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= vrsp_pkg::PADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(int nch, int lm, int im, int rt, int ls, int le);
    reg_write(vrsp_pkg::REG_CHANNELS, 32'(nch));
    reg_write(vrsp_pkg::REG_LOOP_MODE, 32'(lm));
    reg_write(vrsp_pkg::REG_INTERP_MODE, 32'(im));
    reg_write(vrsp_pkg::REG_PLAYBACK_RATE, 32'(rt) & 32'hFFFFF);
    reg_write(vrsp_pkg::REG_LOOP_START, 32'(ls));
    reg_write(vrsp_pkg::REG_LOOP_END, 32'(le));
  endtask

  task automatic load_span(int lo, int hi);
    for (int a = lo; a <= hi; a++) send_item(vrsp_pkg::FUNC_LOAD, 16'(a), 16'($urandom));
  endtask

  // Pick an address that is already loaded, so rewrites never open holes.
  function automatic logic [15:0] loaded_addr();
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 63));
    return 16'($urandom_range(65504, 65535));
  endfunction

  // Start, then a run of beats: mostly ticks, some noise when mixed.
  task automatic play(int count, bit mixed);
    int r;
    send_item(vrsp_pkg::FUNC_START, 16'($urandom), 16'($urandom));
    for (int i = 0; i < count; i++) begin
      r = mixed ? $urandom_range(0, 99) : 0;
      if (r < 76) send_item(vrsp_pkg::FUNC_TICK, 16'($urandom), 16'($urandom));
      else if (r < 84) send_item(vrsp_pkg::FUNC_LOAD, loaded_addr(), 16'($urandom));
      else if (r < 89) send_item(vrsp_pkg::FUNC_LOAD, 16'($urandom), 16'($urandom));
      else if (r < 95) send_item(vrsp_pkg::FUNC_START, 16'($urandom), 16'($urandom));
      else send_item(FUNC_SPARE, 16'($urandom), 16'($urandom));
    end
    drain();
  endtask

  function automatic int pick_rate();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return RATE_LO;
      1: return RATE_HI;
      2: return 0;
      3, 4: return $urandom_range(0, 2 * UNITY) - UNITY;
      5, 6: return $urandom_range(0, 4 * UNITY) - 2 * UNITY;
      default: return $urandom_range(0, RATE_HI - RATE_LO) + RATE_LO;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int ls, le, phases;
    rst = 1;
    item_valid = 0;
    item = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    eager_tx = 0; eager_rx = 0; hold_req = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Tick while stopped and the spare code: neither may give a beat.
    send_item(vrsp_pkg::FUNC_TICK, 16'h0, 16'h0);
    send_item(FUNC_SPARE, 16'hFFFF, 16'hFFFF);
    // Sample words at both data extremes, then the two played areas.
    send_item(vrsp_pkg::FUNC_LOAD, 16'd0, 16'h8000);
    send_item(vrsp_pkg::FUNC_LOAD, 16'd1, 16'h7FFF);
    eager_tx = 1;
    load_span(2, 63);
    eager_tx = 0;
    load_span(65504, 65535);

    // Default registers: forward at unity, one channel, from word 0.
    play(4, 0);

    // Directed settings across the register extremes.
    configure(8, vrsp_pkg::MODE_STOP, 1, RATE_HI, 8, 48);         play(6, 0);
    configure(1, vrsp_pkg::MODE_PINGPONG, 1, RATE_LO, 8, 40);     play(6, 0);
    configure(0, vrsp_pkg::MODE_REPEAT, 0, 0, 8, 30);             play(3, 0);
    configure(15, vrsp_pkg::MODE_REPEAT, 1, -98304, 10, 34);      play(6, 0);
    configure(2, vrsp_pkg::MODE_PINGPONG, 1, 40000, 20, 28);      play(8, 0);
    configure(3, vrsp_pkg::MODE_STOP, 0, 65536, 65520, 65536);    play(5, 0);
    configure(1, 3, 1, -UNITY, 65535, 0);                         play(3, 0);
    configure(1, vrsp_pkg::MODE_PINGPONG, 0, UNITY, 65535, 0);    play(2, 0);

    // Pressure: hold results off while ticks keep arriving at full rate.
    configure(8, vrsp_pkg::MODE_REPEAT, 1, 90000, 8, 48);
    eager_tx = 1;
    hold_req = 1;
    play(12, 0);
    eager_tx = 0;

    // Random settings, mostly well-formed playback with some noise mixed in.
    phases = 0;
    while (sb.items < 175) begin
      if ($urandom_range(0, 3) != 0) begin
        ls = $urandom_range(8, 20);
        le = $urandom_range(1, 48);
      end else begin
        ls = $urandom_range(65512, 65530);
        le = $urandom_range(0, 1) ? 65536 : $urandom_range(ls, 65535);
      end
      configure($urandom_range(0, 15), $urandom_range(0, 3), $urandom_range(0, 1),
                pick_rate(), ls, le);
      eager_tx = $urandom_range(0, 4) == 0;
      eager_rx = $urandom_range(0, 4) == 0;
      play($urandom_range(4, 10), 1);
      phases++;
    end
    eager_tx = 0;
    eager_rx = 0;
    drain();

    $display("run covered %0d input beats over %0d random settings", sb.items, phases);
    $display("checked %0d result beats, %0d of them end-of-play", sb.beats, sb.end_beats);
    if (sb.errors == 0) $display("** variable_rate_sample_player_top: PASSED **");
    else $display("** variable_rate_sample_player_top: FAILED **");
    $finish;
  end

  // Hard limit on the whole run.
  initial begin
    #4000000;
    $display("** variable_rate_sample_player_top: FAILED **");
    $finish;
  end

endmodule

// File: files.f
design/vrsp_pkg.sv
design/vrsp_front.sv
design/vrsp_back.sv
design/variable_rate_sample_player_top.sv
tb/sv/variable_rate_sample_player_top_tb.sv
